>>> src/sct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants for the source code tokenizer
// Lexer mode codes, token type codes and the per-byte request bundle.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_COMMENT = 4'd1;
    localparam logic [3:0] M_OP      = 4'd2;
    localparam logic [3:0] M_RCHECK  = 4'd3;
    localparam logic [3:0] M_IDENT   = 4'd4;
    localparam logic [3:0] M_NUMZ    = 4'd5;
    localparam logic [3:0] M_NUM     = 4'd6;
    localparam logic [3:0] M_STRP    = 4'd7;
    localparam logic [3:0] M_ESCP    = 4'd8;
    localparam logic [3:0] M_STRR    = 4'd9;
    localparam logic [3:0] M_ESCR    = 4'd10;

    localparam logic [8:0] T_EOF     = 9'd0;
    localparam logic [8:0] T_ERROR   = 9'd1;
    localparam logic [8:0] T_IDENT   = 9'd256;
    localparam logic [8:0] TK_STRING = 9'd277;
    localparam logic [8:0] TK_DOTDOT = 9'd278;
    localparam logic [8:0] TK_NUMBER = 9'd292;

    localparam int MAX_RES = 4;

    // One result slot as the front end decides it; positions are added later
    typedef struct packed {
        logic       kind;
        logic [7:0] text;
        logic [8:0] ttype;
        logic       use_cur;   // use current line and column+1 (EOF)
    } slot_t;

    // Two-char operator table
    function automatic logic [8:0] op_pair(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] t;
        t = 9'd0;
        case (a)
            8'h2B: t = (b == 8'h2B) ? 9'd257 : (b == 8'h3D) ? 9'd259 : 9'd0;
            8'h2D: t = (b == 8'h2D) ? 9'd258 : (b == 8'h3D) ? 9'd260 :
                       (b == 8'h3E) ? 9'd268 : 9'd0;
            8'h2A: t = (b == 8'h2A) ? 9'd261 : (b == 8'h3D) ? 9'd262 : 9'd0;
            8'h2F: t = (b == 8'h3D) ? 9'd263 : 9'd0;
            8'h3D: t = (b == 8'h3D) ? 9'd264 : (b == 8'h3E) ? 9'd267 : 9'd0;
            8'h3E: t = (b == 8'h3D) ? 9'd265 : (b == 8'h3E) ? 9'd270 : 9'd0;
            8'h3C: t = (b == 8'h3D) ? 9'd266 : (b == 8'h3C) ? 9'd269 : 9'd0;
            8'h21: t = (b == 8'h3D) ? 9'd273 : (b == 8'h21) ? 9'd272 : 9'd0;
            8'h3A: t = (b == 8'h3D) ? 9'd275 : (b == 8'h3A) ? 9'd274 : 9'd0;
            8'h7C: t = (b == 8'h7C) ? 9'd280 : 9'd0;
            8'h26: t = (b == 8'h26) ? 9'd281 : 9'd0;
            8'h2E: t = (b == 8'h2E) ? TK_DOTDOT : 9'd0;
            default: t = 9'd0;
        endcase
        return t;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == 8'h5F;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Keyword match on the first six characters and saturating length
    function automatic logic [8:0] ident_type(input logic [47:0] kb, input logic [2:0] len);
        logic [8:0] t;
        t = T_IDENT;
        if (len == 3'd2 && kb[15:0] == 16'h6669) t = 9'd282;           // if
        if (len == 3'd4 && kb[31:0] == 32'h66696C65) t = 9'd283;       // elif
        if (len == 3'd4 && kb[31:0] == 32'h65736C65) t = 9'd284;       // else
        if (len == 3'd3 && kb[23:0] == 24'h726F66) t = 9'd285;         // for
        if (len == 3'd6 && kb == 48'h6E7275746572) t = 9'd286;         // return
        if (len == 3'd2 && kb[15:0] == 16'h726F) t = 9'd287;           // or
        if (len == 3'd3 && kb[23:0] == 24'h646E61) t = 9'd288;         // and
        if (len == 3'd2 && kb[15:0] == 16'h7369) t = 9'd289;           // is
        if (len == 3'd2 && kb[15:0] == 16'h6E69) t = 9'd290;           // in
        return t;
    endfunction

endpackage

>>> src/sct_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_front: lexer front end
// Accepts one byte per cycle when in_fire is high, advances the lexer state and
// produces up to three result slots with their token positions into the request queue.
// ----------------------------------------------------------------------------
module sct_front
    import sct_pkg::*;
#(
    parameter int PW = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic [7:0]            char_in,
    input  logic                  end_of_input,
    output slot_t [MAX_RES-1:0]   slots,
    output logic  [2:0]           slot_cnt,
    output logic  [2:0]           slot_split,
    output logic  [PW-1:0]        s_line,
    output logic  [PW-1:0]        s_col,
    output logic  [PW-1:0]        c_line,
    output logic  [PW-1:0]        c_col
);

    localparam logic [PW-1:0] PMAX = '1;

    logic [3:0]    mode_reg, mode_next;
    logic [7:0]    pend_reg, pend_next;
    logic [7:0]    quote_reg, quote_next;
    logic [47:0]   kb_reg, kb_next;
    logic [2:0]    len_reg, len_next;
    logic [PW-1:0] line_reg, line_next, col_reg, col_next;
    logic [PW-1:0] sline_reg, sline_next, scol_reg, scol_next;

    // Lexer next-state and slot generation
    always_comb
    begin
        logic [7:0]  c;
        logic [8:0]  t;
        logic        restart;
        logic        ident_fin;
        logic [47:0] kb_tmp;
        logic [2:0]  len_tmp;
        c = char_in;
        t = 9'd0;
        restart = 1'b0;
        ident_fin = 1'b0;
        kb_tmp = kb_reg;
        len_tmp = len_reg;
        mode_next = mode_reg;
        pend_next = pend_reg;
        quote_next = quote_reg;
        kb_next = kb_reg;
        len_next = len_reg;
        line_next = line_reg;
        col_next = col_reg;
        sline_next = sline_reg;
        scol_next = scol_reg;
        slots = '0;
        slot_cnt = 3'd0;
        // first slot that takes the new start position; 7 means none
        slot_split = 3'd7;

        if (end_of_input) begin
            // flush pending token then EOF
            case (mode_reg)
                M_OP:
                begin
                    slots[0] = '{1'b1, 8'd0, {1'b0, pend_reg}, 1'b0};
                    slot_cnt = 3'd1;
                end
                M_RCHECK:
                begin
                    slots[0] = '{1'b0, pend_reg, 9'd0, 1'b0};
                    slots[1] = '{1'b1, 8'd0, ident_type({40'd0, pend_reg}, 3'd1), 1'b0};
                    slot_cnt = 3'd2;
                    kb_next = {40'd0, pend_reg};
                    len_next = 3'd1;
                end
                M_IDENT:
                begin
                    slots[0] = '{1'b1, 8'd0, ident_type(kb_reg, len_reg), 1'b0};
                    slot_cnt = 3'd1;
                end
                M_NUMZ, M_NUM:
                begin
                    slots[0] = '{1'b1, 8'd0, TK_NUMBER, 1'b0};
                    slot_cnt = 3'd1;
                end
                M_STRP, M_ESCP, M_STRR, M_ESCR:
                begin
                    slots[0] = '{1'b1, 8'd0, T_ERROR, 1'b0};
                    slot_cnt = 3'd1;
                end
                default: ;
            endcase
            slots[slot_cnt[1:0]] = '{1'b1, 8'd0, T_EOF, 1'b1};
            slot_cnt = slot_cnt + 3'd1;
            mode_next = M_IDLE;
        end else begin
            // counters
            if (c == 8'h0A) begin
                col_next = '0;
                if (line_reg != PMAX) line_next = line_reg + 1'b1;
            end else if (col_reg != PMAX) begin
                col_next = col_reg + 1'b1;
            end
            case (mode_reg)
                M_COMMENT:
                    if (c == 8'h0A) mode_next = M_IDLE;
                M_OP:
                begin
                    t = op_pair(pend_reg, c);
                    if (t != 9'd0) begin
                        slots[0] = '{1'b1, 8'd0, t, 1'b0};
                        slot_cnt = 3'd1;
                        mode_next = M_IDLE;
                    end else if (pend_reg == 8'h2E && is_digit(c)) begin
                        slots[0] = '{1'b0, 8'h2E, 9'd0, 1'b0};
                        slots[1] = '{1'b0, c, 9'd0, 1'b0};
                        slot_cnt = 3'd2;
                        mode_next = M_NUM;
                    end else begin
                        slots[0] = '{1'b1, 8'd0, {1'b0, pend_reg}, 1'b0};
                        slot_cnt = 3'd1;
                        restart = 1'b1;
                    end
                end
                M_RCHECK:
                    if (c == 8'h22 || c == 8'h27) begin
                        quote_next = c;
                        mode_next = M_STRR;
                    end else begin
                        slots[0] = '{1'b0, pend_reg, 9'd0, 1'b0};
                        slot_cnt = 3'd1;
                        kb_tmp = {40'd0, pend_reg};
                        len_tmp = 3'd1;
                        ident_fin = 1'b1;
                    end
                M_IDENT: ident_fin = 1'b1;
                M_NUMZ, M_NUM:
                begin
                    mode_next = M_NUM;
                    if (mode_reg == M_NUMZ && (c == 8'h78 || c == 8'h58 || c == 8'h6F ||
                        c == 8'h4F || c == 8'h62 || c == 8'h42)) begin
                        slots[0] = '{1'b0, c, 9'd0, 1'b0};
                        slot_cnt = 3'd1;
                    end else if (c == 8'h5F) begin
                        slot_cnt = 3'd0;
                    end else if (is_digit(c) || c == 8'h2E || c == 8'h65 || c == 8'h45) begin
                        slots[0] = '{1'b0, c, 9'd0, 1'b0};
                        slot_cnt = 3'd1;
                    end else if (c == 8'h66 || c == 8'h46 || c == 8'h67 || c == 8'h47) begin
                        slots[0] = '{1'b0, c, 9'd0, 1'b0};
                        slots[1] = '{1'b1, 8'd0, TK_NUMBER, 1'b0};
                        slot_cnt = 3'd2;
                        mode_next = M_IDLE;
                    end else begin
                        slots[0] = '{1'b1, 8'd0, TK_NUMBER, 1'b0};
                        slot_cnt = 3'd1;
                        restart = 1'b1;
                    end
                end
                M_STRP, M_STRR:
                    if (c == quote_reg) begin
                        slots[0] = '{1'b1, 8'd0, TK_STRING, 1'b0};
                        slot_cnt = 3'd1;
                        mode_next = M_IDLE;
                    end else if (c == 8'h5C) begin
                        mode_next = (mode_reg == M_STRP) ? M_ESCP : M_ESCR;
                        if (mode_reg == M_STRR) begin
                            slots[0] = '{1'b0, 8'h5C, 9'd0, 1'b0};
                            slot_cnt = 3'd1;
                        end
                    end else begin
                        slots[0] = '{1'b0, c, 9'd0, 1'b0};
                        slot_cnt = 3'd1;
                    end
                M_ESCP:
                begin
                    case (c)
                        8'h6E: slots[0] = '{1'b0, 8'h0A, 9'd0, 1'b0};
                        8'h74: slots[0] = '{1'b0, 8'h09, 9'd0, 1'b0};
                        8'h72: slots[0] = '{1'b0, 8'h0D, 9'd0, 1'b0};
                        8'h62: slots[0] = '{1'b0, 8'h08, 9'd0, 1'b0};
                        default: slots[0] = '{1'b0, c, 9'd0, 1'b0};
                    endcase
                    slot_cnt = 3'd1;
                    mode_next = M_STRP;
                end
                M_ESCR:
                begin
                    slots[0] = '{1'b0, c, 9'd0, 1'b0};
                    slot_cnt = 3'd1;
                    mode_next = M_STRR;
                end
                default: restart = 1'b1;
            endcase

            // identifier continuation
            if (ident_fin) begin
                if (is_word(c)) begin
                    slots[slot_cnt[1:0]] = '{1'b0, c, 9'd0, 1'b0};
                    slot_cnt = slot_cnt + 3'd1;
                    if (len_tmp < 3'd6) kb_tmp[8*len_tmp +: 8] = c;
                    if (len_tmp < 3'd7) len_tmp = len_tmp + 3'd1;
                    mode_next = M_IDENT;
                end else begin
                    slots[slot_cnt[1:0]] = '{1'b1, 8'd0, ident_type(kb_tmp, len_tmp), 1'b0};
                    slot_cnt = slot_cnt + 3'd1;
                    restart = 1'b1;
                end
                kb_next = kb_tmp;
                len_next = len_tmp;
            end

            // start of a new token from this byte
            if (restart) begin
                slot_split = slot_cnt;
                sline_next = line_reg;
                scol_next = col_reg;
                if (c == 8'h0A) begin
                    scol_next = '0;
                    if (line_reg != PMAX) sline_next = line_reg + 1'b1;
                end else if (col_reg != PMAX) begin
                    scol_next = col_reg + 1'b1;
                end
                mode_next = M_IDLE;
                if (is_space(c)) begin
                    mode_next = M_IDLE;
                end else if (c == 8'h23) begin
                    mode_next = M_COMMENT;
                end else if (op_pair(c, c) != 9'd0 || c == 8'h2F || c == 8'h3C ||
                             c == 8'h3E || c == 8'h3D) begin
                    pend_next = c;
                    mode_next = M_OP;
                end else if (c == 8'h3B || c == 8'h28 || c == 8'h29 || c == 8'h5B ||
                             c == 8'h5D || c == 8'h7B || c == 8'h7D || c == 8'h40 ||
                             c == 8'h5E || c == 8'h25 || c == 8'h3F || c == 8'h2C) begin
                    slots[slot_cnt[1:0]] = '{1'b1, 8'd0, {1'b0, c}, 1'b0};
                    slot_cnt = slot_cnt + 3'd1;
                end else if (c == 8'h22 || c == 8'h27) begin
                    quote_next = c;
                    mode_next = M_STRP;
                end else if (c == 8'h72 || c == 8'h52) begin
                    pend_next = c;
                    mode_next = M_RCHECK;
                end else if (is_digit(c)) begin
                    slots[slot_cnt[1:0]] = '{1'b0, c, 9'd0, 1'b0};
                    slot_cnt = slot_cnt + 3'd1;
                    mode_next = (c == 8'h30) ? M_NUMZ : M_NUM;
                end else if (is_alpha(c) || c == 8'h5F) begin
                    slots[slot_cnt[1:0]] = '{1'b0, c, 9'd0, 1'b0};
                    slot_cnt = slot_cnt + 3'd1;
                    kb_next = {40'd0, c};
                    len_next = 3'd1;
                    mode_next = M_IDENT;
                end else begin
                    slots[slot_cnt[1:0]] = '{1'b1, 8'd0, T_ERROR, 1'b0};
                    slot_cnt = slot_cnt + 3'd1;
                end
            end
        end
    end

    // Positions: slots before a restart use the old start; later ones the new
    assign s_line = sline_reg;
    assign s_col  = scol_reg;
    assign c_line = line_reg;
    assign c_col  = (col_reg != PMAX) ? col_reg + 1'b1 : col_reg;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= M_IDLE;
            pend_reg  <= '0;
            quote_reg <= '0;
            kb_reg    <= '0;
            len_reg   <= '0;
            line_reg  <= PW'(1);
            col_reg   <= '0;
            sline_reg <= PW'(1);
            scol_reg  <= '0;
        end else if (in_fire) begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            quote_reg <= quote_next;
            kb_reg    <= kb_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
        end
    end

endmodule

>>> src/sct_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_back: result sequencer
// Holds a short queue of decoded byte requests and streams their result
// slots one per cycle, when the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module sct_back
    import sct_pkg::*;
#(
    parameter int PW = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  slot_t [MAX_RES-1:0]   p_slots,
    input  logic  [2:0]           p_cnt,
    input  logic  [PW-1:0]        p_old_line,
    input  logic  [PW-1:0]        p_old_col,
    input  logic  [PW-1:0]        p_new_line,
    input  logic  [PW-1:0]        p_new_col,
    input  logic  [PW-1:0]        p_cur_line,
    input  logic  [PW-1:0]        p_cur_col,
    input  logic  [2:0]           p_split,
    output logic                  full,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  item_kind,
    output logic  [7:0]           text_byte,
    output logic  [8:0]           token_type,
    output logic  [PW-1:0]        token_line,
    output logic  [PW-1:0]        token_column,
    output logic                  last_of_run
);

    typedef struct packed {
        slot_t [MAX_RES-1:0] s;
        logic  [2:0]         cnt;
        logic  [2:0]         split;
        logic  [PW-1:0]      ol, oc, nl, nc, cl, cc;
    } qent_t;

    qent_t      q_reg [2];
    logic [1:0] qv_reg, qv_next;
    logic       wp_reg, rp_reg;
    logic [1:0] idx_reg;
    logic       ov_reg;
    logic       ok_reg;
    logic [7:0] ob_reg;
    logic [8:0] ot_reg;
    logic [PW-1:0] ol_reg, oc_reg;
    logic       olast_reg;

    qent_t      h;
    slot_t      cs;
    logic       take;
    logic       hv;
    logic       last_slot;
    logic [PW-1:0] ln, cn;

    assign h         = q_reg[rp_reg];
    assign hv        = qv_reg[rp_reg];
    assign cs        = h.s[idx_reg];
    assign take      = hv && (!ov_reg || !out_stall);
    assign full      = qv_reg[wp_reg];
    assign last_slot = ({1'b0, idx_reg} + 3'd1 == h.cnt);

    // Position for the current slot
    always_comb
    begin
        if (cs.use_cur) begin
            ln = h.cl;
            cn = h.cc;
        end else if ({1'b0, idx_reg} >= h.split) begin
            ln = h.nl;
            cn = h.nc;
        end else begin
            ln = h.ol;
            cn = h.oc;
        end
    end

    // Queue occupancy
    always_comb
    begin
        qv_next = qv_reg;
        if (take && last_slot) qv_next[rp_reg] = 1'b0;
        if (push) qv_next[wp_reg] = 1'b1;
    end

    // Queue, slot index and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            qv_reg  <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            qv_reg <= qv_next;
            if (take) begin
                ov_reg <= 1'b1;
            end else if (!out_stall) begin
                ov_reg <= 1'b0;
            end
            if (take) begin
                if (last_slot) begin
                    idx_reg <= '0;
                    rp_reg <= ~rp_reg;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            if (push) begin
                wp_reg <= ~wp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            q_reg[wp_reg] <= '{p_slots, p_cnt, p_split, p_old_line, p_old_col,
                               p_new_line, p_new_col, p_cur_line, p_cur_col};
        end
        if (take) begin
            ok_reg    <= cs.kind;
            ob_reg    <= cs.text;
            ot_reg    <= cs.ttype;
            ol_reg    <= ln;
            oc_reg    <= cn;
            olast_reg <= last_slot;
        end
    end

    assign out_valid    = ov_reg;
    assign item_kind    = ok_reg;
    assign text_byte    = ob_reg;
    assign token_type   = ot_reg;
    assign token_line   = ol_reg;
    assign token_column = oc_reg;
    assign last_of_run  = olast_reg;

    // A queued entry always carries at least one slot
    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        hv |-> h.cnt != 3'd0) else $error("queued entry with no results");
    // Output payload holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg && $stable(ot_reg))
        else $error("output changed under stall");
    // Never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("queue overflow");

endmodule

>>> src/source_code_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_code_tokenizer: streaming lexer top level
// Each byte's results pass from the two-entry request queue into the output
// register. Throughput: one byte per cycle while in_stall is low; a byte
// holds the head of the request queue until its last result is taken, and
// its results leave in turn. Bytes with no results are never queued.
// Reset: asynchronous, active low; mode idle, line 1, column 0, queue empty.
// ----------------------------------------------------------------------------
module source_code_tokenizer
    import sct_pkg::*;
#(
    parameter int POSITION_WIDTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                char_in,
    input  logic                      end_of_input,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      item_kind,
    output logic [7:0]                text_byte,
    output logic [8:0]                token_type,
    output logic [POSITION_WIDTH-1:0] token_line,
    output logic [POSITION_WIDTH-1:0] token_column,
    output logic                      last_of_run
);

    slot_t [MAX_RES-1:0]       slots;
    logic  [2:0]               cnt;
    logic  [POSITION_WIDTH-1:0] sl, sc, cl, cc, nl, nc;
    logic  [2:0]               split;
    logic                      full, fire;

    assign in_stall = full;
    assign fire     = in_valid && !full;

    sct_front #(.PW(POSITION_WIDTH)) u_front (
        .clk, .rst_n, .in_fire(fire), .char_in, .end_of_input,
        .slots, .slot_cnt(cnt), .slot_split(split),
        .s_line(sl), .s_col(sc), .c_line(cl), .c_col(cc)
    );

    // New start position (after this byte's counter update)
    always_comb
    begin
        logic [POSITION_WIDTH-1:0] pmax;
        pmax = '1;
        nl = cl;
        nc = cl;
        if (char_in == 8'h0A) begin
            nc = '0;
            nl = (cl != pmax) ? cl + 1'b1 : cl;
        end else begin
            nl = cl;
            nc = cc;   // cc already holds column+1 saturated
        end
    end

    sct_back #(.PW(POSITION_WIDTH)) u_back (
        .clk, .rst_n, .push(fire && cnt != 3'd0), .p_slots(slots), .p_cnt(cnt),
        .p_old_line(sl), .p_old_col(sc), .p_new_line(nl), .p_new_col(nc),
        .p_cur_line(cl), .p_cur_col(cc), .p_split(split), .full,
        .out_valid, .out_stall, .item_kind, .text_byte, .token_type,
        .token_line, .token_column, .last_of_run
    );

endmodule
